// ----- src/apam_pkg.sv -----
// ----------------------------------------------------------------------------
// apam_pkg
// Shared types and constants for the affine pixel address mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package apam_pkg;

    // Default frame size
    localparam int APAM_FRAME_COLUMNS = 1024;
    localparam int APAM_FRAME_ROWS    = 1024;

    // Field and datapath widths
    localparam int COL_W     = 10;   // source column
    localparam int ROW_W     = 12;   // source row
    localparam int ADDR_W    = 10;   // output address fields
    localparam int ORIGIN_W  = 32;   // 16.16 start point
    localparam int STEP_W    = 24;   // 8.16 step
    localparam int OFFSET_W  = 12;   // texel row offset
    localparam int DCOL_W    = COL_W + 1;          // signed column offset
    localparam int TEXROW_W  = ROW_W + 2;          // signed texel row
    localparam int PROD_R_W  = ROW_W + 1 + STEP_W; // row * row_step
    localparam int PROD_C_W  = DCOL_W + STEP_W;    // dcol * col_step
    localparam int SUM_W     = 38;                 // exact 22.16 sum
    localparam int FRAC_W    = 16;
    localparam int COORD_W   = SUM_W - FRAC_W;     // rounded integer coordinate

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Rounding bias: one half in 22.16
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(32768);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_COL_STEP_X   = 3'd2,
        CFG_COL_STEP_Y   = 3'd3,
        CFG_ROW_STEP_X   = 3'd4,
        CFG_ROW_STEP_Y   = 3'd5,
        CFG_FIRST_COLUMN = 3'd6,
        CFG_ROW_OFFSET   = 3'd7
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_column;
        logic [ADDR_W-1:0] dest_row;
        logic [ADDR_W-1:0] texel_column;
        logic [ADDR_W-1:0] texel_row;
    } t_out_item;

    // Stage load enables shared with the axis datapaths
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

// ----- src/apam_axis.sv -----
// ----------------------------------------------------------------------------
// apam_axis
// One axis of the affine map: two products, exact sum, round to nearest.
// Products in stage 2, sum and floor in stage 3.
// ----------------------------------------------------------------------------
`default_nettype none

module apam_axis
    import apam_pkg::*;
(
    input  wire                               i_clk,
    input  wire t_stage_en                    i_en,
    input  wire logic        [ROW_W-1:0]      i_row,
    input  wire logic signed [DCOL_W-1:0]     i_dcol,
    input  wire logic signed [ORIGIN_W-1:0]   i_origin,
    input  wire logic signed [STEP_W-1:0]     i_row_step,
    input  wire logic signed [STEP_W-1:0]     i_col_step,
    output logic signed      [COORD_W-1:0]    o_coord
);

    logic signed [ROW_W:0]      row_s;
    logic signed [PROD_R_W-1:0] n_prod_row;
    logic signed [PROD_C_W-1:0] n_prod_col;
    logic signed [PROD_R_W-1:0] r_prod_row;
    logic signed [PROD_C_W-1:0] r_prod_col;
    logic signed [SUM_W-1:0]    sum;
    logic signed [COORD_W-1:0]  r_coord;

    // Stage 2: products
    always_comb begin
        row_s      = $signed({1'b0, i_row});
        n_prod_row = PROD_R_W'(row_s) * PROD_R_W'(i_row_step);
        n_prod_col = PROD_C_W'(i_dcol) * PROD_C_W'(i_col_step);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod_row <= n_prod_row;
            r_prod_col <= n_prod_col;
        end
    end

    // Stage 3: exact sum plus one half, floor by dropping the fraction
    always_comb begin
        sum = SUM_W'(i_origin) + SUM_W'(r_prod_row) + SUM_W'(r_prod_col) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_coord <= sum[SUM_W-1:FRAC_W];
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

// ----- src/affine_pixel_address_mapper.sv -----
// ----------------------------------------------------------------------------
// affine_pixel_address_mapper
// Maps a source (column, row) affinely to a destination pixel in 16.16 fixed
// point, rounds to nearest and flags pixels that fall outside the frame.
//
//   Channel   Signals                              Direction
//   input     i_in_valid / o_in_ready / i_in       in
//   output    o_out_valid / i_out_ready / o_out    out
//   config    i_cfg_we / i_cfg_index / i_cfg_data  in, write only
//
// Four register stages: operand prep, multiply, sum and round, range check.
// One transaction per clock sustained while the output is ready; the
// multiplier and the wide adder each get a stage of their own.
// Synchronous active-low reset clears the valid bits and loads register
// defaults. A stalled output holds every stage that is full; empty stages
// still fill, so no bubble is lost and nothing is repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_pixel_address_mapper
    import apam_pkg::*;
#(
    parameter int FRAME_COLUMNS = APAM_FRAME_COLUMNS,
    parameter int FRAME_ROWS    = APAM_FRAME_ROWS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire t_in_item                i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output t_out_item                    o_out,
    input  wire                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic signed [COORD_W-1:0]  COORD_COLS = COORD_W'(FRAME_COLUMNS);
    localparam logic signed [COORD_W-1:0]  COORD_ROWS = COORD_W'(FRAME_ROWS);
    localparam logic signed [TEXROW_W-1:0] TEX_COLS   = TEXROW_W'(FRAME_COLUMNS);
    localparam logic signed [TEXROW_W-1:0] TEX_ROWS   = TEXROW_W'(FRAME_ROWS);

    // Configuration registers
    logic signed [ORIGIN_W-1:0] r_origin_x;
    logic signed [ORIGIN_W-1:0] r_origin_y;
    logic signed [STEP_W-1:0]   r_col_step_x;
    logic signed [STEP_W-1:0]   r_col_step_y;
    logic signed [STEP_W-1:0]   r_row_step_x;
    logic signed [STEP_W-1:0]   r_row_step_y;
    logic [COL_W-1:0]           r_first_column;
    logic signed [OFFSET_W-1:0] r_row_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_col_step_x   <= STEP_W'(65536);
            r_col_step_y   <= '0;
            r_row_step_x   <= '0;
            r_row_step_y   <= STEP_W'(65536);
            r_first_column <= '0;
            r_row_offset   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                CFG_COL_STEP_X:   r_col_step_x   <= i_cfg_data[STEP_W-1:0];
                CFG_COL_STEP_Y:   r_col_step_y   <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_STEP_X:   r_row_step_x   <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_STEP_Y:   r_row_step_y   <= i_cfg_data[STEP_W-1:0];
                CFG_FIRST_COLUMN: r_first_column <= i_cfg_data[COL_W-1:0];
                CFG_ROW_OFFSET:   r_row_offset   <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and load enables; a stage loads when empty or draining
    logic      r_v1, r_v2, r_v3, r_v4;
    logic      en1, en2, en3, en4;
    t_stage_en axis_en;

    always_comb begin
        en4         = !r_v4 || i_out_ready;
        en3         = !r_v3 || en4;
        en2         = !r_v2 || en3;
        en1         = !r_v1 || en2;
        axis_en.s2  = en2;
        axis_en.s3  = en3;
    end

    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: column offset and texel row
    logic [COL_W-1:0]           r1_column;
    logic [ROW_W-1:0]           r1_row;
    logic signed [DCOL_W-1:0]   r1_dcol;
    logic signed [TEXROW_W-1:0] r1_tex_row;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_column  <= i_in.column;
            r1_row     <= i_in.row;
            r1_dcol    <= $signed({1'b0, i_in.column}) - $signed({1'b0, r_first_column});
            r1_tex_row <= TEXROW_W'(r_row_offset) + $signed(TEXROW_W'(i_in.row));
        end
    end

    // Side fields carried alongside the axis datapaths
    logic [COL_W-1:0]           r2_column, r3_column;
    logic signed [TEXROW_W-1:0] r2_tex_row, r3_tex_row;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_column  <= r1_column;
            r2_tex_row <= r1_tex_row;
        end
        if (en3) begin
            r3_column  <= r2_column;
            r3_tex_row <= r2_tex_row;
        end
    end

    // Stages 2 and 3: x and y datapaths
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    apam_axis u_axis_x (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_row      (r1_row),
        .i_dcol     (r1_dcol),
        .i_origin   (r_origin_x),
        .i_row_step (r_row_step_x),
        .i_col_step (r_col_step_x),
        .o_coord    (coord_x)
    );

    apam_axis u_axis_y (
        .i_clk      (i_clk),
        .i_en       (axis_en),
        .i_row      (r1_row),
        .i_dcol     (r1_dcol),
        .i_origin   (r_origin_y),
        .i_row_step (r_row_step_y),
        .i_col_step (r_col_step_y),
        .o_coord    (coord_y)
    );

    // Stage 4: frame check and output register
    logic      in_frame;
    t_out_item n_out;
    t_out_item r_out;

    always_comb begin
        in_frame = (r3_tex_row >= 0) && (r3_tex_row < TEX_ROWS)
                && ($signed(TEXROW_W'(r3_column)) < TEX_COLS)
                && (coord_x >= 0) && (coord_x < COORD_COLS)
                && (coord_y >= 0) && (coord_y < COORD_ROWS);
        n_out.write_enable = in_frame;
        n_out.dest_column  = in_frame ? coord_x[ADDR_W-1:0] : '0;
        n_out.dest_row     = in_frame ? coord_y[ADDR_W-1:0] : '0;
        n_out.texel_column = r3_column;
        n_out.texel_row    = r3_tex_row[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out       = r_out;

endmodule

`default_nettype wire
